FILE: design/dogp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogp_pkg
// Shared constants for the difference of Gaussians point evaluator.
// ----------------------------------------------------------------------------
package dogp_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 14;

    localparam int AMP_W = 16;
    localparam int RAD_W = 16;
    localparam int OFS_W = 20;
    localparam int R2_W  = 2 * RAD_W;
    localparam int CFG_W = 20;
    localparam int IDX_W = 3;
    localparam int KV_W  = 16;
    localparam int Q_W   = 31;

    localparam logic [IDX_W-1:0] CFG_CENTER_AMP      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_CENTER_RADIUS   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_SURROUND_AMP    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_SURROUND_RADIUS = 3'd3;
    localparam logic [IDX_W-1:0] CFG_OFFSET_X        = 3'd4;
    localparam logic [IDX_W-1:0] CFG_OFFSET_Y        = 3'd5;

    localparam logic signed [AMP_W-1:0] RST_CENTER_AMP   = 16'sd16384;
    localparam logic signed [AMP_W-1:0] RST_SURROUND_AMP = 16'sd655;
    localparam logic [R2_W-1:0]         RST_CENTER_R2    = 32'd1638400;
    localparam logic [R2_W-1:0]         RST_SURROUND_R2  = 32'd40960000;

    localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [31:0]    RECIP3  = 32'hAAAA_AAAB;

endpackage

FILE: design/dogp_pt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogp_pt_if
// Request channel carrying one grid coordinate.
// ----------------------------------------------------------------------------
interface dogp_pt_if #(
    parameter int COORD_BITS = dogp_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

FILE: design/dogp_kv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogp_kv_if
// Result channel carrying one kernel value.
// ----------------------------------------------------------------------------
interface dogp_kv_if;
    logic                              valid;
    logic                              ready;
    logic signed [dogp_pkg::KV_W-1:0]  kernel_value;

    modport source (output valid, output kernel_value, input ready);
    modport sink   (input valid, input kernel_value, output ready);
endinterface

FILE: design/dogp_gauss.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dogp_gauss
// Pipelined exp(-d2/r2) in Q30: one quotient bit per stage, then a Horner
// polynomial and eight squarings, one multiply per stage.
// ----------------------------------------------------------------------------
module dogp_gauss #(
    parameter int FRAC_BITS = dogp_pkg::FRAC_BITS_DEF,
    parameter int D2W       = 43
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [D2W-1:0]              i_d2,
    input  logic [dogp_pkg::R2_W-1:0]   i_r2,
    output logic [dogp_pkg::Q_W-1:0]    o_g
);
    localparam int NQ  = FRAC_BITS + 5;
    localparam int USH = 22 - FRAC_BITS;
    localparam int UW  = NQ + USH;
    localparam int MW  = UW + 1;
    localparam int DVW = D2W + FRAC_BITS;
    localparam int QW  = dogp_pkg::Q_W;
    localparam int PW  = UW + QW;

    logic [DVW-1:0] r_rem [0:NQ];
    logic [NQ-1:0]  r_q   [0:NQ];
    logic           r_zd  [0:NQ];

    // Far tail or zero radius forces the term to zero at the end.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {i_d2, {FRAC_BITS{1'b0}}};
            r_q[0]   <= '0;
            r_zd[0]  <= (i_r2 == '0) || (i_d2 > D2W'({i_r2, 4'b0000}));
        end
    end

    for (genvar s = 0; s < NQ; s++) begin : g_div
        localparam int K = NQ - 1 - s;
        logic [DVW-1:0] w_sh;
        logic           w_ge;
        assign w_sh = DVW'(i_r2) << K;
        assign w_ge = r_rem[s] >= w_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? (r_rem[s] - w_sh) : r_rem[s];
                r_q[s+1]   <= {r_q[s][NQ-2:0], w_ge};
                r_zd[s+1]  <= r_zd[s];
            end
        end
    end

    logic [UW-1:0]   w_u;
    logic [UW-1:0]   r_u0, r_u1, r_u2, r_u3, r_u4, r_u5;
    logic [QW-1:0]   r_a0, r_a1, r_a2;
    logic [MW-1:0]   r_m1, r_m2, r_m3;
    logic [MW-2:0]   r_d3;
    logic [PW-1:0]   w_p1, w_p2, w_p3;
    logic [MW+31:0]  w_pd;
    logic [6:0]      r_zp;
    logic [QW-1:0]   r_e  [0:8];
    logic            r_zs [0:8];

    assign w_u  = {r_q[NQ], {USH{1'b0}}};
    assign w_p1 = PW'(r_u0) * PW'(r_a0);
    assign w_pd = (MW+32)'(r_m1) * (MW+32)'(dogp_pkg::RECIP3);
    assign w_p2 = PW'(r_u3) * PW'(r_a1);
    assign w_p3 = PW'(r_u5) * PW'(r_a2);

    // Horner steps: a = 1 - u/4, 1 - (u*a)/3, 1 - (u*a)/2, e = 1 - u*a.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u0  <= w_u;
            r_a0  <= dogp_pkg::Q30_ONE - QW'(w_u >> 2);
            r_u1  <= r_u0;
            r_m1  <= w_p1[PW-1:30];
            r_u2  <= r_u1;
            r_d3  <= w_pd[MW+31:33];
            r_u3  <= r_u2;
            r_a1  <= dogp_pkg::Q30_ONE - QW'(r_d3);
            r_u4  <= r_u3;
            r_m2  <= w_p2[PW-1:30];
            r_u5  <= r_u4;
            r_a2  <= dogp_pkg::Q30_ONE - QW'(r_m2 >> 1);
            r_m3  <= w_p3[PW-1:30];
            r_e[0] <= dogp_pkg::Q30_ONE - QW'(r_m3);
            r_zp  <= {r_zp[5:0], r_zd[NQ]};
            r_zs[0] <= r_zp[6];
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_sq
        logic [2*QW-1:0] w_sq;
        assign w_sq = (2*QW)'(r_e[j]) * (2*QW)'(r_e[j]);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (j == 7 && r_zs[j]) begin
                    r_e[j+1] <= '0;
                end else begin
                    r_e[j+1] <= w_sq[QW+29:30];
                end
                r_zs[j+1] <= r_zs[j];
            end
        end
    end

    assign o_g = r_e[8];
endmodule

FILE: design/difference_of_gaussians_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// difference_of_gaussians_point
// Difference of two Gaussians evaluated at one integer grid point.
// ----------------------------------------------------------------------------
// The block takes one (pos_x, pos_y) request per cycle unless the result
// port stalls, and returns
// kernel_value = center_amp * exp(-d2/rc^2) - surround_amp * exp(-d2/rs^2),
// rounded and saturated to signed Q2.14, where d2 is the squared distance to
// the configured centre. It is a fully pipelined datapath: the front end,
// two restoring dividers producing one quotient bit per stage, the Horner
// polynomial, eight squarings and the back end. All stages share one advance
// enable, so when the result port stalls the whole pipeline holds and nothing
// is dropped or repeated. Configuration registers are written through a
// simple write port and must only change while no request is in flight. A
// radius write stores the radius squared, which the dividers use directly.
// ----------------------------------------------------------------------------
module difference_of_gaussians_point #(
    parameter int COORD_BITS = dogp_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dogp_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dogp_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [dogp_pkg::CFG_W-1:0]   i_cfg_data,
    dogp_pt_if.sink                      i_pt,
    dogp_kv_if.source                    o_kv
);
    // Widths of the distance path follow the coordinate width.
    localparam int PXW = COORD_BITS + 8;
    localparam int AW  = ((PXW > dogp_pkg::OFS_W) ? PXW : dogp_pkg::OFS_W) + 1;
    localparam int DXW = AW + 1;
    localparam int D2W = 2 * AW + 1;
    localparam int GL  = FRAC_BITS + 22;
    localparam int LAT = GL + 7;
    localparam int PRW = dogp_pkg::AMP_W + dogp_pkg::Q_W + 1;
    localparam int SMW = PRW + 1;

    // Configuration registers.
    logic signed [dogp_pkg::AMP_W-1:0] r_camp, r_samp;
    logic [dogp_pkg::R2_W-1:0]         r_rc2, r_rs2;
    logic signed [dogp_pkg::OFS_W-1:0] r_offx, r_offy;
    logic [dogp_pkg::R2_W-1:0]         w_rad2;

    assign w_rad2 = dogp_pkg::R2_W'(i_cfg_data[dogp_pkg::RAD_W-1:0])
                  * dogp_pkg::R2_W'(i_cfg_data[dogp_pkg::RAD_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camp <= dogp_pkg::RST_CENTER_AMP;
            r_samp <= dogp_pkg::RST_SURROUND_AMP;
            r_rc2  <= dogp_pkg::RST_CENTER_R2;
            r_rs2  <= dogp_pkg::RST_SURROUND_R2;
            r_offx <= '0;
            r_offy <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dogp_pkg::CFG_CENTER_AMP: begin
                    r_camp <= i_cfg_data[dogp_pkg::AMP_W-1:0];
                end
                dogp_pkg::CFG_CENTER_RADIUS: begin
                    r_rc2 <= w_rad2;
                end
                dogp_pkg::CFG_SURROUND_AMP: begin
                    r_samp <= i_cfg_data[dogp_pkg::AMP_W-1:0];
                end
                dogp_pkg::CFG_SURROUND_RADIUS: begin
                    r_rs2 <= w_rad2;
                end
                dogp_pkg::CFG_OFFSET_X: begin
                    r_offx <= i_cfg_data;
                end
                dogp_pkg::CFG_OFFSET_Y: begin
                    r_offy <= i_cfg_data;
                end
                default: begin
                    // Writes to unused indexes are ignored.
                end
            endcase
        end
    end

    // One enable advances every stage; it drops only when the output
    // register holds a result that the sink has not taken.
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en       = !r_vld[LAT-1] || o_kv.ready;
    assign i_pt.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_pt.valid};
        end
    end

    // Front end: signed offsets, magnitudes, squares, squared distance.
    logic [PXW:0]          w_px, w_py;
    logic signed [DXW-1:0] r_dx, r_dy;
    logic [AW-1:0]         r_ax, r_ay;
    logic [2*AW-1:0]       r_sx, r_sy;
    logic [D2W-1:0]        r_d2;

    assign w_px = {1'b0, i_pt.pos_x[COORD_BITS-1:0], 8'h00};
    assign w_py = {1'b0, i_pt.pos_y[COORD_BITS-1:0], 8'h00};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dx <= DXW'(signed'(w_px)) - DXW'(r_offx);
            r_dy <= DXW'(signed'(w_py)) - DXW'(r_offy);
            r_ax <= r_dx[DXW-1] ? AW'(-r_dx) : AW'(r_dx);
            r_ay <= r_dy[DXW-1] ? AW'(-r_dy) : AW'(r_dy);
            r_sx <= (2*AW)'(r_ax) * (2*AW)'(r_ax);
            r_sy <= (2*AW)'(r_ay) * (2*AW)'(r_ay);
            r_d2 <= D2W'(r_sx) + D2W'(r_sy);
        end
    end

    // The two Gaussian terms run side by side on the same distance.
    logic [dogp_pkg::Q_W-1:0] w_gc, w_gs;

    dogp_gauss #(
        .FRAC_BITS (FRAC_BITS),
        .D2W       (D2W)
    ) u_center (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d2  (r_d2),
        .i_r2  (r_rc2),
        .o_g   (w_gc)
    );

    dogp_gauss #(
        .FRAC_BITS (FRAC_BITS),
        .D2W       (D2W)
    ) u_surround (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d2  (r_d2),
        .i_r2  (r_rs2),
        .o_g   (w_gs)
    );

    // Back end: amplitude products, exact difference, then round to Q14
    // (add half and floor) and saturate to 16 bits.
    logic signed [PRW-1:0]          r_pc, r_ps;
    logic signed [SMW-1:0]          r_sum;
    logic signed [SMW-1:0]          w_rnd, w_sh;
    logic signed [dogp_pkg::KV_W-1:0] r_kv;

    assign w_rnd = r_sum + (SMW'(1) <<< 29);
    assign w_sh  = w_rnd >>> 30;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc  <= PRW'(r_camp) * signed'(PRW'(w_gc));
            r_ps  <= PRW'(r_samp) * signed'(PRW'(w_gs));
            r_sum <= SMW'(r_pc) - SMW'(r_ps);
            if (w_sh > SMW'(32767)) begin
                r_kv <= 16'sh7FFF;
            end else if (w_sh < -SMW'(32768)) begin
                r_kv <= -16'sh8000;
            end else begin
                r_kv <= w_sh[dogp_pkg::KV_W-1:0];
            end
        end
    end

    assign o_kv.valid        = r_vld[LAT-1];
    assign o_kv.kernel_value = r_kv;
endmodule
